// ----- src/ldu_spmv_pkg.sv -----
// ----------------------------------------------------------------------------
// ldu_spmv_pkg: shared types and constants
// Opcodes, modes, status codes, controller states and command/status structs
// for the lower-diagonal-upper sparse matrix-vector engine.
// ----------------------------------------------------------------------------
`default_nettype none
package ldu_spmv_pkg;

  localparam int unsigned DEF_MAX_CELLS = 1024;
  localparam int unsigned DEF_MAX_FACES = 4096;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ACC_W  = 48;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned CELL_W = 10;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned FCNT_W = 13;

  typedef enum logic [1:0] {
    OP_LOAD_CELL = 2'd0,
    OP_LOAD_FACE = 2'd1,
    OP_RUN       = 2'd2,
    OP_READ      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_AX    = 2'd0,
    MODE_ATX   = 2'd1,
    MODE_RESID = 2'd2,
    MODE_ROWS  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_CELLS = 2'd1,
    REG_FACES = 2'd2
  } reg_idx_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ_WAIT,  // accumulator read in flight
    S_READ_OUT,
    S_DIAG_RD,    // issue cell reads
    S_DIAG_MUL,   // product register
    S_DIAG_WR,
    S_FACE_RD,    // fetch face record
    S_FACE_VEC,   // fetch vector at owner and neighbour
    S_FACE_MUL,   // products, fetch neighbour accumulator
    S_FACE_WN,    // write neighbour, fetch owner accumulator
    S_FACE_WO,
    S_RUN_ACK
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic cell_rd;    // read cell stores at cell counter
    logic diag_mul;   // register diagonal term
    logic diag_wr;    // write diagonal term to accumulator
    logic face_rd;    // read face stores at face counter
    logic vec_rd;     // read vectors at owner/neighbour, latch face
    logic face_mul;   // register products, read acc[n]
    logic wr_n;       // write acc[n], read acc[o]
    logic wr_o;       // write acc[o]
    logic acc_rd;     // read accumulator at input index
    logic out_read;   // emit read result
    logic out_ack;    // emit run acknowledgement
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic face_skip;  // latched face touches cells out of range
  } ctl_stat_t;

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W+1:0] v);
    logic signed [ACC_W+1:0] mx;
    logic signed [ACC_W+1:0] mn;
    mx = {3'b000, {(ACC_W-1){1'b1}}};
    mn = {3'b111, {(ACC_W-1){1'b0}}};
    if (v > mx) sat48 = mx[ACC_W-1:0];
    else if (v < mn) sat48 = mn[ACC_W-1:0];
    else sat48 = v[ACC_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- src/ldu_spmv_ram.sv -----
// ----------------------------------------------------------------------------
// ldu_spmv_ram: generic memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ldu_spmv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/ldu_spmv_ctrl.sv -----
// ----------------------------------------------------------------------------
// ldu_spmv_ctrl: sequencer
// Walks cells then faces during a run, and steps reads; loads need no states here.
// ----------------------------------------------------------------------------
`default_nettype none
module ldu_spmv_ctrl #(
  parameter int unsigned MAX_CELLS = ldu_spmv_pkg::DEF_MAX_CELLS,
  parameter int unsigned MAX_FACES = ldu_spmv_pkg::DEF_MAX_FACES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [1:0]                    opcode,
  input  wire logic [$clog2(MAX_CELLS+1)-1:0] eff_cells,
  input  wire logic [$clog2(MAX_FACES+1)-1:0] eff_faces,
  input  wire ldu_spmv_pkg::ctl_stat_t       stat,
  output logic                               busy,
  output logic [$clog2(MAX_CELLS+1)-1:0]     cell_cnt,
  output logic [$clog2(MAX_FACES+1)-1:0]     face_cnt,
  output ldu_spmv_pkg::ctl_cmd_t             cmd
);
  localparam int unsigned CC_W = $clog2(MAX_CELLS+1);
  localparam int unsigned FC_W = $clog2(MAX_FACES+1);

  ldu_spmv_pkg::state_t state_r, state_nxt;
  logic [CC_W-1:0] cell_r, cell_nxt;
  logic [FC_W-1:0] face_r, face_nxt;

  assign cell_cnt = cell_r;
  assign face_cnt = face_r;
  assign busy = (state_r != ldu_spmv_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ldu_spmv_pkg::S_IDLE;
      cell_r  <= '0;
      face_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cell_r  <= cell_nxt;
      face_r  <= face_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cell_nxt  = cell_r;
    face_nxt  = face_r;
    unique case (state_r)
      ldu_spmv_pkg::S_IDLE: begin
        if (start) begin
          if (opcode == ldu_spmv_pkg::OP_READ) begin
            state_nxt = ldu_spmv_pkg::S_READ_WAIT;
          end else if (opcode == ldu_spmv_pkg::OP_RUN) begin
            cell_nxt = '0;
            face_nxt = '0;
            state_nxt = (eff_cells != '0) ? ldu_spmv_pkg::S_DIAG_RD
                                          : ldu_spmv_pkg::S_FACE_RD;
          end
        end
      end
      ldu_spmv_pkg::S_READ_WAIT: state_nxt = ldu_spmv_pkg::S_READ_OUT;
      ldu_spmv_pkg::S_READ_OUT:  state_nxt = ldu_spmv_pkg::S_IDLE;
      ldu_spmv_pkg::S_DIAG_RD:   state_nxt = ldu_spmv_pkg::S_DIAG_MUL;
      ldu_spmv_pkg::S_DIAG_MUL:  state_nxt = ldu_spmv_pkg::S_DIAG_WR;
      ldu_spmv_pkg::S_DIAG_WR: begin
        cell_nxt = cell_r + 1'b1;
        state_nxt = (cell_r + 1'b1 < eff_cells) ? ldu_spmv_pkg::S_DIAG_RD
                                                : ldu_spmv_pkg::S_FACE_RD;
      end
      ldu_spmv_pkg::S_FACE_RD: begin
        state_nxt = (face_r < eff_faces) ? ldu_spmv_pkg::S_FACE_VEC
                                         : ldu_spmv_pkg::S_RUN_ACK;
      end
      ldu_spmv_pkg::S_FACE_VEC:  state_nxt = ldu_spmv_pkg::S_FACE_MUL;
      ldu_spmv_pkg::S_FACE_MUL: begin
        if (stat.face_skip) begin
          face_nxt = face_r + 1'b1;
          state_nxt = ldu_spmv_pkg::S_FACE_RD;
        end else begin
          state_nxt = ldu_spmv_pkg::S_FACE_WN;
        end
      end
      ldu_spmv_pkg::S_FACE_WN:   state_nxt = ldu_spmv_pkg::S_FACE_WO;
      ldu_spmv_pkg::S_FACE_WO: begin
        face_nxt = face_r + 1'b1;
        state_nxt = ldu_spmv_pkg::S_FACE_RD;
      end
      ldu_spmv_pkg::S_RUN_ACK:   state_nxt = ldu_spmv_pkg::S_IDLE;
      default:                   state_nxt = ldu_spmv_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ldu_spmv_pkg::S_IDLE:
        cmd.acc_rd = start && (opcode == ldu_spmv_pkg::OP_READ);
      ldu_spmv_pkg::S_READ_OUT: cmd.out_read = 1'b1;
      ldu_spmv_pkg::S_DIAG_RD:  cmd.cell_rd  = 1'b1;
      ldu_spmv_pkg::S_DIAG_MUL: cmd.diag_mul = 1'b1;
      ldu_spmv_pkg::S_DIAG_WR:  cmd.diag_wr  = 1'b1;
      ldu_spmv_pkg::S_FACE_RD:  cmd.face_rd  = 1'b1;
      ldu_spmv_pkg::S_FACE_VEC: cmd.vec_rd   = 1'b1;
      ldu_spmv_pkg::S_FACE_MUL: cmd.face_mul = !stat.face_skip;
      ldu_spmv_pkg::S_FACE_WN:  cmd.wr_n     = 1'b1;
      ldu_spmv_pkg::S_FACE_WO:  cmd.wr_o     = 1'b1;
      ldu_spmv_pkg::S_RUN_ACK:  cmd.out_ack  = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- src/ldu_spmv_dp.sv -----
// ----------------------------------------------------------------------------
// ldu_spmv_dp: datapath
// Cell and face stores, Q16.16 multipliers, saturating accumulator update.
// ----------------------------------------------------------------------------
`default_nettype none
module ldu_spmv_dp #(
  parameter int unsigned MAX_CELLS = ldu_spmv_pkg::DEF_MAX_CELLS,
  parameter int unsigned MAX_FACES = ldu_spmv_pkg::DEF_MAX_FACES
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              load_cell,
  input  wire logic                              load_face,
  input  wire logic [ldu_spmv_pkg::IDX_W-1:0]    idx,
  input  wire logic [31:0]                       a_in,
  input  wire logic [31:0]                       b_in,
  input  wire logic [31:0]                       s_in,
  input  wire logic [ldu_spmv_pkg::CELL_W-1:0]   own_in,
  input  wire logic [ldu_spmv_pkg::CELL_W-1:0]   nbr_in,
  input  wire logic [1:0]                        mode,
  input  wire logic [$clog2(MAX_CELLS+1)-1:0]    eff_cells,
  input  wire logic [$clog2(MAX_CELLS+1)-1:0]    cell_cnt,
  input  wire logic [$clog2(MAX_FACES+1)-1:0]    face_cnt,
  input  wire ldu_spmv_pkg::ctl_cmd_t            cmd,
  output ldu_spmv_pkg::ctl_stat_t                stat,
  output logic                                   out_valid,
  output logic signed [31:0]                     out_value,
  output logic [ldu_spmv_pkg::CELL_W-1:0]        out_cell,
  output logic                                   out_done,
  output logic [1:0]                             out_status
);
  localparam int unsigned CA = $clog2(MAX_CELLS);
  localparam int unsigned FA = $clog2(MAX_FACES);
  localparam int unsigned AW = ldu_spmv_pkg::ACC_W;
  localparam int unsigned CW = ldu_spmv_pkg::CELL_W;

  // cell stores: diag, source one port; vector needs two reads so two copies
  logic [31:0] d_q, s_q, xa_q, xb_q;
  logic [31:0] lo_q, up_q;
  logic [CW-1:0] ow_q, nb_q;
  logic [AW-1:0] acc_q;

  logic [CA-1:0] cell_addr, xa_addr, xb_addr, acc_raddr, acc_waddr;
  logic [AW-1:0] acc_wdata;
  logic          acc_we;
  logic [FA-1:0] face_addr;
  logic [FA-1:0] idx_f;
  logic [CA-1:0] idx_c;

  assign idx_c = CA'(idx);
  assign idx_f = FA'(idx);
  assign cell_addr = cell_cnt[CA-1:0];
  assign face_addr = face_cnt[FA-1:0];

  // latched face record
  logic [CA-1:0] o_r, n_r;
  logic signed [31:0] lo_r, up_r;
  logic skip_r;
  logic signed [AW-1:0] pn_r, po_r;     // terms for acc[n], acc[o]
  logic signed [AW-1:0] diag_r;
  logic [CA-1:0] out_idx_r;
  logic          out_range_r;
  logic [AW-1:0] fwd_r;                 // acc[n] as just written

  assign xa_addr = cmd.cell_rd ? cell_addr : CA'(ow_q);
  assign xb_addr = CA'(nb_q);

  ldu_spmv_ram #(.WIDTH(32), .DEPTH(MAX_CELLS)) u_diag (
    .clk, .we(load_cell), .waddr(idx_c), .wdata(a_in), .raddr(cell_addr), .rdata(d_q));
  ldu_spmv_ram #(.WIDTH(32), .DEPTH(MAX_CELLS)) u_src (
    .clk, .we(load_cell), .waddr(idx_c), .wdata(s_in), .raddr(cell_addr), .rdata(s_q));
  ldu_spmv_ram #(.WIDTH(32), .DEPTH(MAX_CELLS)) u_vec_a (
    .clk, .we(load_cell), .waddr(idx_c), .wdata(b_in), .raddr(xa_addr), .rdata(xa_q));
  ldu_spmv_ram #(.WIDTH(32), .DEPTH(MAX_CELLS)) u_vec_b (
    .clk, .we(load_cell), .waddr(idx_c), .wdata(b_in), .raddr(xb_addr), .rdata(xb_q));
  ldu_spmv_ram #(.WIDTH(32), .DEPTH(MAX_FACES)) u_lo (
    .clk, .we(load_face), .waddr(idx_f), .wdata(a_in), .raddr(face_addr), .rdata(lo_q));
  ldu_spmv_ram #(.WIDTH(32), .DEPTH(MAX_FACES)) u_up (
    .clk, .we(load_face), .waddr(idx_f), .wdata(b_in), .raddr(face_addr), .rdata(up_q));
  ldu_spmv_ram #(.WIDTH(CW), .DEPTH(MAX_FACES)) u_own (
    .clk, .we(load_face), .waddr(idx_f), .wdata(own_in), .raddr(face_addr), .rdata(ow_q));
  ldu_spmv_ram #(.WIDTH(CW), .DEPTH(MAX_FACES)) u_nbr (
    .clk, .we(load_face), .waddr(idx_f), .wdata(nbr_in), .raddr(face_addr), .rdata(nb_q));
  ldu_spmv_ram #(.WIDTH(AW), .DEPTH(MAX_CELLS)) u_acc (
    .clk, .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata), .raddr(acc_raddr), .rdata(acc_q));

  always_comb begin
    if (cmd.acc_rd) acc_raddr = idx_c;
    else if (cmd.face_mul) acc_raddr = n_r;
    else if (cmd.wr_n) acc_raddr = o_r;
    else acc_raddr = out_idx_r;  // keep the read address steady until the result goes out
  end

  // q16.16 products, arithmetic shift floors
  logic signed [63:0] p_d, p_n, p_o;
  logic signed [31:0] cn, co, xo, xn;
  always_comb begin
    xo = xa_q;
    xn = xb_q;
    cn = (mode == ldu_spmv_pkg::MODE_ATX) ? up_r : lo_r;
    co = (mode == ldu_spmv_pkg::MODE_ATX) ? lo_r : up_r;
    p_d = $signed(d_q) * $signed(xa_q);
    p_n = cn * xo;
    p_o = co * xn;
  end

  logic signed [AW+1:0] sum;
  logic signed [AW-1:0] term;
  logic signed [AW-1:0] acc_cur;
  always_comb begin
    acc_we = 1'b0;
    acc_waddr = o_r;
    term = po_r;
    sum = '0;
    // owner equal to neighbour: the memory still holds the value before the write
    acc_cur = (cmd.wr_o && (o_r == n_r)) ? $signed(fwd_r) : $signed(acc_q);
    if (cmd.diag_wr) begin
      acc_we = 1'b1;
      acc_waddr = cell_addr;
      if (mode == ldu_spmv_pkg::MODE_RESID)
        sum = (AW+2)'($signed(s_q)) - (AW+2)'(diag_r);
      else
        sum = (AW+2)'(diag_r);
    end else if (cmd.wr_n || cmd.wr_o) begin
      acc_we = 1'b1;
      acc_waddr = cmd.wr_n ? n_r : o_r;
      term = cmd.wr_n ? pn_r : po_r;
      if (mode == ldu_spmv_pkg::MODE_RESID)
        sum = (AW+2)'(acc_cur) - (AW+2)'(term);
      else
        sum = (AW+2)'(acc_cur) + (AW+2)'(term);
    end
    acc_wdata = ldu_spmv_pkg::sat48(sum);
  end

  assign stat.face_skip = skip_r;

  always_ff @(posedge clk) begin
    if (cmd.diag_mul) begin
      if (mode == ldu_spmv_pkg::MODE_ROWS) diag_r <= AW'($signed(d_q));
      else diag_r <= AW'(p_d >>> 16);
    end
    if (cmd.vec_rd) begin
      o_r  <= CA'(ow_q);
      n_r  <= CA'(nb_q);
      lo_r <= lo_q;
      up_r <= up_q;
      skip_r <= ({1'b0, ow_q} >= (CW+1)'(eff_cells)) ||
                ({1'b0, nb_q} >= (CW+1)'(eff_cells)) ||
                (CA < CW && ((ow_q >> CA) != '0 || (nb_q >> CA) != '0));
    end
    if (cmd.face_mul) begin
      if (mode == ldu_spmv_pkg::MODE_ROWS) begin
        pn_r <= AW'(cn);
        po_r <= AW'(co);
      end else begin
        pn_r <= AW'(p_n >>> 16);
        po_r <= AW'(p_o >>> 16);
      end
    end
    if (cmd.wr_n) begin
      fwd_r <= acc_wdata;
    end
    if (cmd.acc_rd) begin
      out_idx_r   <= idx_c;
      out_range_r <= ({1'b0, idx} >= (ldu_spmv_pkg::IDX_W+1)'(eff_cells));
    end
  end

  logic signed [AW-1:0] acc_s;
  assign acc_s = $signed(acc_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.out_read || cmd.out_ack;
    end
    out_done <= cmd.out_ack;
    if (cmd.out_read) begin
      out_cell <= CW'(out_idx_r);
      if (out_range_r) begin
        out_value  <= '0;
        out_status <= ldu_spmv_pkg::ST_RANGE;
      end else if (acc_s > AW'(64'sh7FFFFFFF)) begin
        out_value  <= 32'sh7FFFFFFF;
        out_status <= ldu_spmv_pkg::ST_SAT;
      end else if (acc_s < -AW'(64'sh80000000)) begin
        out_value  <= 32'sh80000000;
        out_status <= ldu_spmv_pkg::ST_SAT;
      end else begin
        out_value  <= acc_s[31:0];
        out_status <= ldu_spmv_pkg::ST_OK;
      end
    end else begin
      out_value  <= '0;
      out_cell   <= '0;
      out_status <= ldu_spmv_pkg::ST_OK;
    end
  end
endmodule
`default_nettype wire

// ----- src/ldu_sparse_matrix_vector_multiply_top.sv -----
// ----------------------------------------------------------------------------
// ldu_sparse_matrix_vector_multiply_top: ldu sparse matrix-vector engine
// Usage:
//   A request is taken when start is high and busy is low. Loads of cells
//   and faces finish in the accepting cycle and give no result. A read gives
//   one result on out_valid after READ_WAIT, READ_OUT and the output register.
//   A run walks all cells (read, multiply, write), then all faces (read,
//   fetch vectors, multiply, write neighbour, write owner; a face touching
//   cells beyond cell_count ends after the multiply), and then raises
//   out_valid with out_run_done for one cycle; busy stays high until then.
//   Faces are paced by the one read and one write port of the accumulator.
//   Results show for one cycle only; the receiver cannot stall.
//   cfg_* writes take effect at once and must only be issued while idle.
//   Reset (rst_n low, synchronous) sets mode 0, cell_count 1024,
//   face_count 0 and returns the sequencer to idle; stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module ldu_sparse_matrix_vector_multiply_top #(
  parameter int unsigned MAX_CELLS = ldu_spmv_pkg::DEF_MAX_CELLS,
  parameter int unsigned MAX_FACES = ldu_spmv_pkg::DEF_MAX_FACES
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_opcode,
  input  wire logic [11:0]         in_item_index,
  input  wire logic signed [31:0]  in_diag_or_lower_coef,
  input  wire logic signed [31:0]  in_vector_or_upper_coef,
  input  wire logic signed [31:0]  in_source_value,
  input  wire logic [9:0]          in_owner_cell,
  input  wire logic [9:0]          in_neighbour_cell,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [12:0]         cfg_data,
  output logic                     out_valid,
  output logic signed [31:0]       out_result_value,
  output logic [9:0]               out_result_cell,
  output logic                     out_run_done,
  output logic [1:0]               out_status
);
  localparam int unsigned CC_W = $clog2(MAX_CELLS+1);
  localparam int unsigned FC_W = $clog2(MAX_FACES+1);

  logic [1:0]  mode_r;
  logic [10:0] cells_r;
  logic [12:0] faces_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ldu_spmv_pkg::MODE_AX;
      cells_r <= 11'd1024;
      faces_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ldu_spmv_pkg::REG_MODE:  mode_r  <= cfg_data[1:0];
        ldu_spmv_pkg::REG_CELLS: cells_r <= cfg_data[10:0];
        ldu_spmv_pkg::REG_FACES: faces_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // counts clipped to the store depths
  logic [CC_W-1:0] eff_cells;
  logic [FC_W-1:0] eff_faces;
  always_comb begin
    if (32'(cells_r) > MAX_CELLS) eff_cells = CC_W'(MAX_CELLS);
    else eff_cells = CC_W'(cells_r);
    if (32'(faces_r) > MAX_FACES) eff_faces = FC_W'(MAX_FACES);
    else eff_faces = FC_W'(faces_r);
  end

  logic take;
  logic load_cell, load_face;
  assign take = start && !busy;
  assign load_cell = take && (in_opcode == ldu_spmv_pkg::OP_LOAD_CELL) &&
                     (32'(in_item_index) < 32'(eff_cells));
  assign load_face = take && (in_opcode == ldu_spmv_pkg::OP_LOAD_FACE) &&
                     (32'(in_item_index) < 32'(eff_faces));

  ldu_spmv_pkg::ctl_cmd_t  cmd;
  ldu_spmv_pkg::ctl_stat_t stat;
  logic [CC_W-1:0] cell_cnt;
  logic [FC_W-1:0] face_cnt;

  ldu_spmv_ctrl #(.MAX_CELLS(MAX_CELLS), .MAX_FACES(MAX_FACES)) u_ctrl (
    .clk, .rst_n, .start, .opcode(in_opcode), .eff_cells, .eff_faces,
    .stat, .busy, .cell_cnt, .face_cnt, .cmd);

  ldu_spmv_dp #(.MAX_CELLS(MAX_CELLS), .MAX_FACES(MAX_FACES)) u_dp (
    .clk, .rst_n, .load_cell, .load_face, .idx(in_item_index),
    .a_in(in_diag_or_lower_coef), .b_in(in_vector_or_upper_coef),
    .s_in(in_source_value), .own_in(in_owner_cell), .nbr_in(in_neighbour_cell),
    .mode(mode_r), .eff_cells, .cell_cnt, .face_cnt, .cmd, .stat,
    .out_valid, .out_value(out_result_value), .out_cell(out_result_cell),
    .out_done(out_run_done), .out_status);
endmodule
`default_nettype wire

// ----- sim/ldu_sparse_matrix_vector_multiply_top_tb.sv -----
// ----------------------------------------------------------------------------
// ldu_sparse_matrix_vector_multiply_top_tb: self-checking bench for the ldu engine
// Loads cells and faces, issues runs in all four modes and reads back cell
// results. A behavioral copy of the engine predicts each result and every
// result is compared field by field. The cell count is swept across its extremes.
// ----------------------------------------------------------------------------
`default_nettype none
module ldu_sparse_matrix_vector_multiply_top_tb;

  localparam int NCELL = 1024;
  localparam int NFACE = 4096;
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [31:0] value;
    logic [9:0]         res_cell;
    logic               done;
    logic [1:0]         status;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_opcode = '0;
  logic [11:0] in_item_index = '0;
  logic signed [31:0] in_diag_or_lower_coef = '0;
  logic signed [31:0] in_vector_or_upper_coef = '0;
  logic signed [31:0] in_source_value = '0;
  logic [9:0] in_owner_cell = '0;
  logic [9:0] in_neighbour_cell = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic out_valid;
  logic signed [31:0] out_result_value;
  logic [9:0] out_result_cell;
  logic out_run_done;
  logic [1:0] out_status;

  // engine copy
  ldu_spmv_pkg::mode_t cur_mode = ldu_spmv_pkg::MODE_AX;
  int unsigned cur_cells = 1024;
  int unsigned cur_faces = 0;
  logic signed [31:0] diag_mem [NCELL];
  logic signed [31:0] vec_mem [NCELL];
  logic signed [31:0] src_mem [NCELL];
  longint acc_mem [NCELL];
  logic signed [31:0] lo_mem [NFACE];
  logic signed [31:0] up_mem [NFACE];
  logic [9:0] own_mem [NFACE];
  logic [9:0] nbr_mem [NFACE];
  bit face_loaded [NFACE];

  cell_result_t pending_results[$];
  int errors = 0;
  longint cycles = 0;
  int burst_left = 0;

  ldu_sparse_matrix_vector_multiply_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_item_index(in_item_index),
    .in_diag_or_lower_coef(in_diag_or_lower_coef),
    .in_vector_or_upper_coef(in_vector_or_upper_coef),
    .in_source_value(in_source_value), .in_owner_cell(in_owner_cell),
    .in_neighbour_cell(in_neighbour_cell), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_result_value(out_result_value),
    .out_result_cell(out_result_cell), .out_run_done(out_run_done),
    .out_status(out_status)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned live_cells();
    return cur_cells > NCELL ? NCELL : cur_cells;
  endfunction

  function automatic int unsigned live_faces();
    return cur_faces > NFACE ? NFACE : cur_faces;
  endfunction

  // q16.16 product, floor of the shifted full product
  function automatic longint q16_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 16;
  endfunction

  function automatic longint clamp48(longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  function automatic void spmv_sweep();
    int unsigned nc, nf, o, n;
    longint d;
    nc = live_cells();
    nf = live_faces();
    for (int c = 0; c < nc; c++) begin
      d = (cur_mode == ldu_spmv_pkg::MODE_ROWS) ? longint'(diag_mem[c])
                                                : q16_mul(diag_mem[c], vec_mem[c]);
      acc_mem[c] = clamp48(cur_mode == ldu_spmv_pkg::MODE_RESID ?
                           longint'(src_mem[c]) - d : d);
    end
    for (int f = 0; f < nf; f++) begin
      o = own_mem[f];
      n = nbr_mem[f];
      if (o < nc && n < nc) begin
        case (cur_mode)
          ldu_spmv_pkg::MODE_AX: begin
            acc_mem[n] = clamp48(acc_mem[n] + q16_mul(lo_mem[f], vec_mem[o]));
            acc_mem[o] = clamp48(acc_mem[o] + q16_mul(up_mem[f], vec_mem[n]));
          end
          ldu_spmv_pkg::MODE_ATX: begin
            acc_mem[n] = clamp48(acc_mem[n] + q16_mul(up_mem[f], vec_mem[o]));
            acc_mem[o] = clamp48(acc_mem[o] + q16_mul(lo_mem[f], vec_mem[n]));
          end
          ldu_spmv_pkg::MODE_RESID: begin
            acc_mem[n] = clamp48(acc_mem[n] - q16_mul(lo_mem[f], vec_mem[o]));
            acc_mem[o] = clamp48(acc_mem[o] - q16_mul(up_mem[f], vec_mem[n]));
          end
          default: begin
            acc_mem[n] = clamp48(acc_mem[n] + longint'(lo_mem[f]));
            acc_mem[o] = clamp48(acc_mem[o] + longint'(up_mem[f]));
          end
        endcase
      end
    end
  endfunction

  function automatic void predict_request(ldu_spmv_pkg::opcode_t op, logic [11:0] idx,
      logic signed [31:0] a, logic signed [31:0] b, logic signed [31:0] s,
      logic [9:0] own, logic [9:0] nbr);
    cell_result_t r;
    longint v;
    case (op)
      ldu_spmv_pkg::OP_LOAD_CELL: begin
        if (idx < live_cells()) begin
          diag_mem[idx] = a;
          vec_mem[idx] = b;
          src_mem[idx] = s;
        end
      end
      ldu_spmv_pkg::OP_LOAD_FACE: begin
        if (idx < live_faces()) begin
          lo_mem[idx] = a;
          up_mem[idx] = b;
          own_mem[idx] = own;
          nbr_mem[idx] = nbr;
          face_loaded[idx] = 1'b1;
        end
      end
      ldu_spmv_pkg::OP_RUN: begin
        spmv_sweep();
        r = '{value: '0, res_cell: '0, done: 1'b1, status: ldu_spmv_pkg::ST_OK};
        pending_results.push_back(r);
      end
      default: begin
        r = '{value: '0, res_cell: idx[9:0], done: 1'b0, status: ldu_spmv_pkg::ST_RANGE};
        if (idx < live_cells()) begin
          v = acc_mem[idx];
          r.status = ldu_spmv_pkg::ST_OK;
          if (v > 64'sh7FFF_FFFF) begin
            v = 64'sh7FFF_FFFF;
            r.status = ldu_spmv_pkg::ST_SAT;
          end else if (v < -64'sh8000_0000) begin
            v = -64'sh8000_0000;
            r.status = ldu_spmv_pkg::ST_SAT;
          end
          r.value = v[31:0];
        end
        pending_results.push_back(r);
      end
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // result checker, sampled mid-cycle
  always @(negedge clk) begin
    cell_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing outstanding");
      end else begin
        e = pending_results.pop_front();
        if (out_result_value !== e.value || out_result_cell !== e.res_cell ||
            out_run_done !== e.done || out_status !== e.status)
          flag_mismatch($sformatf("got v=%h c=%0d d=%b s=%0d want v=%h c=%0d d=%b s=%0d",
            out_result_value, out_result_cell, out_run_done, out_status,
            e.value, e.res_cell, e.done, e.status));
      end
    end
  end

  task automatic send_request(ldu_spmv_pkg::opcode_t op, logic [11:0] idx,
      logic signed [31:0] a, logic signed [31:0] b, logic signed [31:0] s,
      logic [9:0] own, logic [9:0] nbr);
    bit taken;
    start <= 1'b1;
    in_opcode <= op;
    in_item_index <= idx;
    in_diag_or_lower_coef <= a;
    in_vector_or_upper_coef <= b;
    in_source_value <= s;
    in_owner_cell <= own;
    in_neighbour_cell <= nbr;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    predict_request(op, idx, a, b, s, own, nbr);
  endtask

  // sender bursts with random gaps
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 12);
    end
  endtask

  task automatic write_reg(ldu_spmv_pkg::reg_idx_t r, int unsigned val);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= val[12:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      ldu_spmv_pkg::REG_MODE: cur_mode = ldu_spmv_pkg::mode_t'(val[1:0]);
      ldu_spmv_pkg::REG_CELLS: cur_cells = val[10:0];
      default: cur_faces = val[12:0];
    endcase
  endtask

  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'($urandom_range(0, 262143)) - 32'sd131072;
      3: return 32'sh0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // every face in use must hold a record before any run
  task automatic fill_faces();
    for (int f = 0; f < live_faces(); f++)
      if (!face_loaded[f]) begin
        send_request(ldu_spmv_pkg::OP_LOAD_FACE, f[11:0], pick_q16(), pick_q16(), $urandom,
          10'($urandom_range(0, live_cells() - 1)), 10'($urandom_range(0, live_cells() - 1)));
        pace();
      end
  endtask

  task automatic test_preload();
    // write every cell so that no store is read unwritten later on
    for (int c = 0; c < NCELL; c++) begin
      send_request(ldu_spmv_pkg::OP_LOAD_CELL, c[11:0], pick_q16(), pick_q16(), pick_q16(),
        '0, '0);
      pace();
    end
    send_request(ldu_spmv_pkg::OP_RUN, '0, '0, '0, '0, '0, '0);
  endtask

  task automatic test_corners();
    write_reg(ldu_spmv_pkg::REG_CELLS, 2);
    write_reg(ldu_spmv_pkg::REG_FACES, 3);
    send_request(ldu_spmv_pkg::OP_LOAD_CELL, 12'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
      32'sh8000_0000, '0, '0);
    send_request(ldu_spmv_pkg::OP_LOAD_CELL, 12'd1, 32'sh8000_0000, 32'sh7FFF_FFFF,
      32'sh7FFF_FFFF, '0, '0);
    // ignored: beyond cell count
    send_request(ldu_spmv_pkg::OP_LOAD_CELL, 12'd4095, 32'sd5, 32'sd5, 32'sd5, '0, '0);
    send_request(ldu_spmv_pkg::OP_LOAD_FACE, 12'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0,
      10'd0, 10'd1);
    send_request(ldu_spmv_pkg::OP_LOAD_FACE, 12'd1, 32'sh8000_0000, 32'sh7FFF_FFFF, '0,
      10'd0, 10'd1);
    // face touching a cell beyond the count is skipped
    send_request(ldu_spmv_pkg::OP_LOAD_FACE, 12'd2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0,
      10'd1023, 10'd1);
    send_request(ldu_spmv_pkg::OP_LOAD_FACE, 12'd4095, '0, '0, '0, 10'h3FF, 10'h3FF);
    for (int m = 0; m < 4; m++) begin
      write_reg(ldu_spmv_pkg::REG_MODE, m);
      send_request(ldu_spmv_pkg::OP_RUN, '0, '0, '0, '0, '0, '0);
      send_request(ldu_spmv_pkg::OP_READ, 12'd0, '0, '0, '0, '0, '0);
      send_request(ldu_spmv_pkg::OP_READ, 12'd1, '0, '0, '0, '0, '0);
      send_request(ldu_spmv_pkg::OP_READ, 12'd2, '0, '0, '0, '0, '0);
      send_request(ldu_spmv_pkg::OP_READ, 12'd4095, '0, '0, '0, '0, '0);
    end
    // no cells at all
    write_reg(ldu_spmv_pkg::REG_CELLS, 0);
    send_request(ldu_spmv_pkg::OP_RUN, '0, '0, '0, '0, '0, '0);
    send_request(ldu_spmv_pkg::OP_READ, 12'd0, '0, '0, '0, '0, '0);
  endtask

  task automatic random_phase(int unsigned cells, int unsigned faces, int n_items);
    int unsigned pick, nc;
    logic [11:0] idx;
    write_reg(ldu_spmv_pkg::REG_MODE, $urandom_range(0, 3));
    write_reg(ldu_spmv_pkg::REG_CELLS, cells);
    write_reg(ldu_spmv_pkg::REG_FACES, faces);
    nc = live_cells();
    fill_faces();
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      idx = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, nc));
      if (pick < 30) begin
        send_request(ldu_spmv_pkg::OP_LOAD_CELL, idx, pick_q16(), pick_q16(), pick_q16(),
          10'($urandom), 10'($urandom));
      end else if (pick < 55) begin
        if (live_faces() > 0 && $urandom_range(0, 5) != 0)
          idx = 12'($urandom_range(0, live_faces() - 1));
        else
          idx = 12'($urandom);
        send_request(ldu_spmv_pkg::OP_LOAD_FACE, idx, pick_q16(), pick_q16(), $urandom,
          ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, nc - 1)),
          ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, nc - 1)));
      end else if (pick < 68) begin
        send_request(ldu_spmv_pkg::OP_RUN, 12'($urandom), $urandom, $urandom, $urandom,
          10'($urandom), 10'($urandom));
      end else begin
        send_request(ldu_spmv_pkg::OP_READ, idx, $urandom, $urandom, $urandom,
          10'($urandom), 10'($urandom));
      end
      pace();
    end
    send_request(ldu_spmv_pkg::OP_RUN, '0, '0, '0, '0, '0, '0);
  endtask

  task automatic test_random_modes();
    for (int p = 0; p < 5; p++)
      random_phase($urandom_range(1, 48), $urandom_range(0, 12), 12);
    random_phase(1, 1, 10);
  endtask

  task automatic test_full_size();
    // a cell count above the store depth saturates
    random_phase(2047, 16, 10);
    write_reg(ldu_spmv_pkg::REG_CELLS, 1024);
    send_request(ldu_spmv_pkg::OP_RUN, '0, '0, '0, '0, '0, '0);
    send_request(ldu_spmv_pkg::OP_READ, 12'd1023, '0, '0, '0, '0, '0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_preload();
    test_corners();
    test_random_modes();
    test_full_size();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
